FILE: rtl/htprb_pkg.sv
// ----------------------------------------------------------------------------
// Hash probe unit package
// Shared widths, operation and status codes, the probe sequence, and the
// command/status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package htprb_pkg;

  // Table geometry
  localparam int SLOTS    = 8;
  localparam int IDX_BITS = 3;
  localparam int CNT_BITS = 4;
  localparam int KEY_BITS = 31;

  // Stream widths (payload padded to whole bytes)
  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // Offsets added to the home slot, one per probe step
  localparam logic [IDX_BITS-1:0] PROBE_OFS [SLOTS] = '{
    3'd0, 3'd2, 3'd6, 3'd7, 3'd3, 3'd1, 3'd4, 3'd5
  };

  // Controller -> datapath
  typedef struct packed {
    logic                load;     // capture the input transfer
    logic                probe;    // evaluate the slot at step
    logic                publish;  // move the result into the output register
    logic [IDX_BITS-1:0] step;     // current probe step
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic resolve;   // operation finishes at this probe step
    logic out_free;  // output register can take a result this cycle
  } stat_t;

endpackage

FILE: rtl/hash_table_pseudorandom_probe_unit.sv
// ----------------------------------------------------------------------------
// Hash table probe unit
// Eight-slot open-addressing key set with pseudo-random probe order.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tuser carries the operation (insert, find, remove,
//   clear) and tdata the key. Output stream m_axis returns one result per
//   operation: status, slot and the number of keys held afterwards.
//   One operation is processed at a time. After an input transfer the unit
//   probes one slot per cycle, up to all eight slots (clear and insert into a
//   full table stop at the first step), then loads the output register. The
//   unit takes no new operation until the probe walk is through and the
//   result has moved to the output register; the probe walk, a single slot
//   read and compare per cycle, sets the pace.
//   The output register decouples the sides: the next operation is accepted
//   while a result still waits. When the receiver stalls, the finished
//   operation holds until the output register frees, and s_axis_tready stays
//   low meanwhile.
//   Reset (rst, synchronous) empties the table, clears the count and drops
//   m_axis_tvalid.
// ----------------------------------------------------------------------------
module hash_table_pseudorandom_probe_unit (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: key[30:0], pad[31]
  input  logic [htprb_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // tuser: action[1:0]
  input  logic [htprb_pkg::S_USER_W-1:0]  s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: status[1:0], slot[4:2], key_count[8:5], pad[15:9]
  output logic [htprb_pkg::M_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);
  import htprb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  htprb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  htprb_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

FILE: rtl/htprb_ctrl.sv
// ----------------------------------------------------------------------------
// Hash probe controller
// Sequences one operation: accept, walk the probe steps until the datapath
// resolves, then hand the result to the output register.
// ----------------------------------------------------------------------------
module htprb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  htprb_pkg::stat_t  stat,
  output htprb_pkg::cmd_t   cmd
);
  import htprb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [IDX_BITS-1:0] step, step_next;

  // Next state and command decode
  always_comb begin
    state_next    = state;
    step_next     = step;
    s_axis_tready = 1'b0;
    cmd           = '0;
    cmd.step      = step;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (stat.resolve) begin
          state_next = S_DONE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

FILE: rtl/htprb_dp.sv
// ----------------------------------------------------------------------------
// Hash probe datapath
// Holds the slot table, live/used flags and key count, evaluates one probe
// step per cycle, and owns the output register.
// ----------------------------------------------------------------------------
module htprb_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [htprb_pkg::S_DATA_W-1:0]    s_axis_tdata,
  input  logic [htprb_pkg::S_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [htprb_pkg::M_DATA_W-1:0]    m_axis_tdata,
  input  htprb_pkg::cmd_t                   cmd,
  output htprb_pkg::stat_t                  stat
);
  import htprb_pkg::*;

  // Operation registers
  action_t             act_r;
  logic [KEY_BITS-1:0] key_r;

  // Table
  logic [KEY_BITS-1:0] slot_key [SLOTS];
  logic [SLOTS-1:0]    slot_live;
  logic [SLOTS-1:0]    slot_used;
  logic [CNT_BITS-1:0] held_count;

  // Result registers
  status_t             res_status;
  logic [IDX_BITS-1:0] res_slot;

  // Probe evaluation
  logic [IDX_BITS-1:0] idx;
  logic                key_eq;
  logic                last;
  logic                resolve;
  status_t             st_next;
  logic [IDX_BITS-1:0] slot_next;
  logic                do_write;
  logic                do_remove;
  logic                do_clear;

  // Decide the outcome of the current probe step
  always_comb begin
    idx       = key_r[IDX_BITS-1:0] + PROBE_OFS[cmd.step];
    key_eq    = (slot_key[idx] == key_r);
    last      = (cmd.step == IDX_BITS'(SLOTS - 1));
    resolve   = 1'b0;
    st_next   = ST_OK;
    slot_next = '0;
    do_write  = 1'b0;
    do_remove = 1'b0;
    do_clear  = 1'b0;
    unique case (act_r) inside
      ACT_INSERT: begin
        if (held_count == CNT_BITS'(SLOTS)) begin
          resolve = 1'b1;
          st_next = ST_FULL;
        end else if (!slot_live[idx]) begin
          resolve   = 1'b1;
          do_write  = 1'b1;
          slot_next = idx;
        end else if (key_eq) begin
          resolve   = 1'b1;
          st_next   = ST_DUP;
          slot_next = idx;
        end else if (last) begin
          resolve = 1'b1;
          st_next = ST_FULL;
        end
      end
      ACT_FIND, ACT_REMOVE: begin
        // walk stops at a never-used slot; tombstones are skipped
        if (!slot_used[idx]) begin
          resolve = 1'b1;
          st_next = ST_MISS;
        end else if (slot_live[idx] && key_eq) begin
          resolve   = 1'b1;
          slot_next = idx;
          do_remove = (act_r == ACT_REMOVE);
        end else if (last) begin
          resolve = 1'b1;
          st_next = ST_MISS;
        end
      end
      ACT_CLEAR: begin
        resolve  = 1'b1;
        do_clear = 1'b1;
      end
      default: begin
        resolve = 1'b1;
      end
    endcase
  end

  assign stat.resolve  = resolve;
  assign stat.out_free = !m_axis_tvalid || m_axis_tready;

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(s_axis_tuser);
      key_r <= s_axis_tdata[KEY_BITS-1:0];
    end
  end

  // Key store, written on insert
  always_ff @(posedge clk) begin
    if (cmd.probe && resolve && do_write) begin
      slot_key[idx] <= key_r;
    end
  end

  // Flags and count
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_live  <= '0;
      slot_used  <= '0;
      held_count <= '0;
    end else if (cmd.probe && resolve) begin
      if (do_clear) begin
        slot_live  <= '0;
        slot_used  <= '0;
        held_count <= '0;
      end else if (do_write) begin
        slot_live[idx] <= 1'b1;
        slot_used[idx] <= 1'b1;
        held_count     <= held_count + 1'b1;
      end else if (do_remove) begin
        slot_live[idx] <= 1'b0;
        held_count     <= held_count - 1'b1;
      end
    end
  end

  // Result latch
  always_ff @(posedge clk) begin
    if (cmd.probe && resolve) begin
      res_status <= st_next;
      res_slot   <= slot_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.publish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      m_axis_tdata <= {(M_DATA_W - CNT_BITS - IDX_BITS - 2)'(0),
                       held_count, res_slot, res_status};
    end
  end

`ifndef SYNTHESIS
  // count always tracks the number of live slots
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    held_count == CNT_BITS'($countones(slot_live)))
    else $error("key count does not match live slots");

  // a live slot is always marked as used
  a_live_used: assert property (@(posedge clk) disable iff (rst)
    (slot_live & ~slot_used) == '0)
    else $error("live slot not marked used");

  // a pending result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result published over a pending transfer");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hash probe unit testbench
// Drives insert, find, remove and clear operations into the probe unit. A
// scoreboard keeps its own copy of the eight-slot table and predicts status,
// slot and key count for every operation. Results are compared in order,
// field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module tb_top;
  import htprb_pkg::*;

  // Probe walk: offsets added to the home slot, in visiting order
  localparam logic [2:0] WALK_OFS [8] = '{3'd0, 3'd2, 3'd6, 3'd7, 3'd3, 3'd1, 3'd4, 3'd5};
  localparam int unsigned NO_SLOT = 8;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_OPS  = 2000;

  typedef struct {
    status_t    status;
    logic [2:0] slot;
    logic [3:0] key_count;
  } probe_result_t;

  // Table shadow plus the queue of results still owed by the unit
  class probe_scoreboard;
    logic [30:0]   slot_key [8];
    bit            slot_live [8];
    bit            slot_used [8];
    int unsigned   held;
    probe_result_t owed_results [$];
    int unsigned   mismatches;

    function new();
      wipe_table();
      mismatches = 0;
    endfunction

    function void wipe_table();
      for (int i = 0; i < 8; i++) begin
        slot_key[i]  = '0;
        slot_live[i] = 1'b0;
        slot_used[i] = 1'b0;
      end
      held = 0;
    endfunction

    // Walk stops at the first never-used slot; match needs a live slot
    function int unsigned find_slot(logic [30:0] key);
      logic [2:0]  idx;
      int unsigned hit;
      hit = NO_SLOT;
      for (int s = 0; s < 8; s++) begin
        idx = key[2:0] + WALK_OFS[s];
        if (!slot_used[idx]) break;
        if (slot_live[idx] && slot_key[idx] == key) begin
          hit = 32'(idx);
          break;
        end
      end
      return hit;
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void note_op(action_t act, logic [30:0] key);
      probe_result_t res;
      logic [2:0]    idx;
      int unsigned   hit;
      res.status = ST_OK;
      res.slot   = '0;
      case (act)
        ACT_INSERT: begin
          if (held >= 8) begin
            res.status = ST_FULL;
          end else begin
            for (int s = 0; s < 8; s++) begin
              idx = key[2:0] + WALK_OFS[s];
              if (!slot_live[idx]) begin
                slot_key[idx]  = key;
                slot_live[idx] = 1'b1;
                slot_used[idx] = 1'b1;
                held++;
                res.slot = idx;
                break;
              end
              if (slot_key[idx] == key) begin
                res.status = ST_DUP;
                res.slot   = idx;
                break;
              end
            end
          end
        end
        ACT_FIND: begin
          hit = find_slot(key);
          if (hit != NO_SLOT) res.slot = hit[2:0];
          else res.status = ST_MISS;
        end
        ACT_REMOVE: begin
          hit = find_slot(key);
          if (held == 0 || hit == NO_SLOT) begin
            res.status = ST_MISS;
          end else begin
            slot_live[hit] = 1'b0;
            held--;
            res.slot = hit[2:0];
          end
        end
        default: wipe_table();
      endcase
      res.key_count = held[3:0];
      owed_results.insert(owed_results.size(), res);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // tdata: status[1:0], slot[4:2], key_count[8:5]
    task check_result(logic [15:0] data);
      probe_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result tdata=0x%04h", data));
      end else begin
        want = owed_results.pop_front();
        if (data[1:0] != want.status)
          report($sformatf("status %0d, expected %0d", data[1:0], want.status));
        if (data[4:2] != want.slot)
          report($sformatf("slot %0d, expected %0d", data[4:2], want.slot));
        if (data[8:5] != want.key_count)
          report($sformatf("key_count %0d, expected %0d", data[8:5], want.key_count));
      end
    endtask

    function int unsigned pending();
      return owed_results.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic [S_USER_W-1:0] s_axis_tuser;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;

  probe_scoreboard sb;
  bit              steady;
  int unsigned     cycles;
  logic [30:0]     key_pool [12];

  hash_table_pseudorandom_probe_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    steady        = 1'b0;
    cycles        = 0;
    sb            = new();
  end

  // Receiver: random back-pressure, none while steady
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 19);
  end

  // Result check on each output transfer
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One input transfer, with optional idle cycles ahead of it
  task automatic send_op(action_t act, logic [30:0] key);
    while (!steady && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, key};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_op(act, key);
  endtask

  // Keys spread over all eight homes, some homes shared, so probe walks collide
  task automatic refill_pool();
    logic [31:0] rnd;
    for (int i = 0; i < 12; i++) begin
      rnd         = $urandom;
      key_pool[i] = {rnd[30:3], 3'(i * 3)};
    end
  endtask

  task automatic random_op(bit fill_mode);
    int unsigned roll;
    int unsigned kroll;
    action_t     act;
    logic [31:0] rnd;
    logic [30:0] key;
    roll  = $urandom_range(99);
    kroll = $urandom_range(99);
    rnd   = $urandom;
    if (fill_mode) begin
      if (roll < 60) act = ACT_INSERT;
      else if (roll < 80) act = ACT_FIND;
      else if (roll < 98) act = ACT_REMOVE;
      else act = ACT_CLEAR;
    end else begin
      if (roll < 25) act = ACT_INSERT;
      else if (roll < 55) act = ACT_FIND;
      else if (roll < 97) act = ACT_REMOVE;
      else act = ACT_CLEAR;
    end
    if (kroll < 3) key = '0;
    else if (kroll < 6) key = '1;
    else if (kroll < 16) key = rnd[30:0];
    else key = key_pool[$urandom_range(11)];
    send_op(act, key);
  endtask

  initial begin
    bit fill_mode;
    fill_mode = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, duplicates, full table, tombstones, clear
    send_op(ACT_REMOVE, 31'd5);          // remove from empty set
    send_op(ACT_FIND,   31'd0);          // find on empty set
    send_op(ACT_INSERT, 31'd0);
    send_op(ACT_INSERT, 31'd0);          // duplicate
    send_op(ACT_INSERT, 31'h7FFF_FFFF);  // largest key, home slot 7
    send_op(ACT_INSERT, 31'd8);          // same home as 0, walk the offsets
    send_op(ACT_INSERT, 31'd16);
    send_op(ACT_INSERT, 31'd24);
    send_op(ACT_INSERT, 31'd32);
    send_op(ACT_INSERT, 31'd40);
    send_op(ACT_INSERT, 31'd48);         // table now full
    send_op(ACT_INSERT, 31'd56);         // insert into full set
    send_op(ACT_INSERT, 31'd0);          // full wins over duplicate
    send_op(ACT_REMOVE, 31'd16);         // leaves a tombstone
    send_op(ACT_FIND,   31'd24);         // walks past the tombstone
    send_op(ACT_FIND,   31'd64);         // miss after a full walk
    send_op(ACT_INSERT, 31'd24);         // lands in tombstone ahead of live copy
    send_op(ACT_REMOVE, 31'h7FFF_FFFF);
    send_op(ACT_FIND,   31'h7FFF_FFFF);
    send_op(ACT_REMOVE, 31'd99);         // absent key, non-empty set
    send_op(ACT_CLEAR,  31'h5555_5555);
    send_op(ACT_FIND,   31'd0);
    send_op(ACT_REMOVE, 31'd0);
    send_op(ACT_INSERT, 31'h2AAA_AAAA);
    send_op(ACT_CLEAR,  31'd0);

    // Random: alternate fill-heavy and drain-heavy stretches
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 250 == 0) refill_pool();
      if (n % 100 == 0) fill_mode = ~fill_mode;
      steady = (n >= 900 && n < 1300);
      random_op(fill_mode);
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    // Drain, then let the output side settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
